/* sv/dht_pkg.sv */
// Shared types and constants for the double hash table.
`timescale 1ns / 1ps
`default_nettype none
package dht_pkg;
   localparam int MAX_LOG2_SLOTS_DEF = 12;
   localparam int KEY_BYTES_DEF      = 8;
   localparam int HASH_BITS_DEF      = 32;
   localparam int LOG2_W             = 4;
   localparam int CNT_W              = 32;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_INSERTED  = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic OP_SEARCH = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_RD      = 10'b0000000100,
      S_SLOT    = 10'b0000001000,
      S_CMP     = 10'b0000010000,
      S_DONE    = 10'b0000100000,
      S_WCLR    = 10'b0001000000,
      S_WRD     = 10'b0010000000,
      S_WSLOT   = 10'b0100000000,
      S_WPROBE  = 10'b1000000000
   } state_type;
endpackage
`default_nettype wire

/* sv/dht_slot_ram.sv */
// Single slot table memory: one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dht_slot_ram #(
   parameter int AW = 12,
   parameter int DW = 13
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [2**AW];

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/dht_entry_ram.sv */
// Entry store: hash, length and key per entry id.
`timescale 1ns / 1ps
`default_nettype none
module dht_entry_ram #(
   parameter int AW = 12,
   parameter int DW = 100
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);
   logic [DW-1:0] mem [2**AW];

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/double_hash_table_find_or_insert.sv */
// Top level: sequencer, probe unit and memories of the hash table.
//
// A request is taken when start is high and busy low; its word appears on
// the rsp_ ports for one cycle with done high, and busy stays high in that
// cycle. Each probe that meets a stored entry passes through slot read,
// entry read and compare, and the probe that ends on an empty slot stops
// after the slot read; a report step follows, an order set by the single
// read port of each memory. An insert that brings the load to 3/4 doubles
// the table: the new table is cleared and each old slot is walked, an
// empty one skipped and a stored one read, rehashed and probed until an
// empty new slot takes it. After reset or a csr_ write every slot of both
// tables is cleared, while busy is high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module double_hash_table_find_or_insert #(
   parameter int MAX_LOG2_SLOTS = dht_pkg::MAX_LOG2_SLOTS_DEF,
   parameter int KEY_BYTES      = dht_pkg::KEY_BYTES_DEF,
   parameter int HASH_BITS      = dht_pkg::HASH_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [63:0] req_key_bytes,
   input  wire logic [3:0]  req_key_length,
   input  wire logic [31:0] req_key_hash,
   output logic             done,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_entry_id,
   output logic [3:0]       rsp_table_log2_slots,
   output logic [31:0]      rsp_search_count,
   output logic [31:0]      rsp_collision_count,
   output logic [3:0]       rsp_expansion_count,
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_wdata
);
   localparam int AW      = MAX_LOG2_SLOTS;
   localparam int SLOTS   = 2**AW;
   localparam int ENT_MAX = (SLOTS / 4) * 3;
   localparam int IW      = AW;
   localparam int SW      = IW + 1;
   localparam int EDW     = HASH_BITS + 4 + 64;
   localparam int LW      = dht_pkg::LOG2_W;

   dht_pkg::state_type state_ff, state_in;

   logic [LW-1:0]  init_ff, init_in;
   logic [LW-1:0]  size_ff, size_in;
   logic [IW:0]    count_ff, count_in;
   logic [31:0]    srch_ff, srch_in;
   logic [31:0]    coll_ff, coll_in;
   logic [3:0]     exp_ff, exp_in;
   logic           sel_ff, sel_in;
   logic [AW:0]    ptr_ff, ptr_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  step_ff, step_in;
   logic [AW:0]    n_ff, n_in;
   logic           op_ff, op_in;
   logic [63:0]    key_ff, key_in;
   logic [3:0]     len_ff, len_in;
   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic [IW-1:0]  id_ff, id_in;
   logic           done_ff, done_in;
   logic [1:0]     stat_ff, stat_in;
   logic [11:0]    rid_ff, rid_in;

   // memory ports
   logic           wa_en, wb_en;
   logic [AW-1:0]  wa_addr, wb_addr, ra_addr, rb_addr;
   logic [SW-1:0]  wa_data, wb_data, ra_data, rb_data;
   logic           ew_en;
   logic [IW-1:0]  ew_addr, er_addr;
   logic [EDW-1:0] ew_data, er_data;

   dht_slot_ram #(.AW(AW), .DW(SW)) u_tab_a (
      .clock(clock), .wr_en(wa_en), .wr_addr(wa_addr), .wr_data(wa_data),
      .rd_addr(ra_addr), .rd_data(ra_data));
   dht_slot_ram #(.AW(AW), .DW(SW)) u_tab_b (
      .clock(clock), .wr_en(wb_en), .wr_addr(wb_addr), .wr_data(wb_data),
      .rd_addr(rb_addr), .rd_data(rb_data));
   dht_entry_ram #(.AW(IW), .DW(EDW)) u_ent (
      .clock(clock), .wr_en(ew_en), .wr_addr(ew_addr), .wr_data(ew_data),
      .rd_addr(er_addr), .rd_data(er_data));

   // derived sizes
   logic [AW:0]   slots;
   logic [AW:0]   mask_w;
   logic [AW-1:0] mask;
   logic [AW-1:0] mask2;
   logic          at_max;
   logic [IW+2:0] load4, slots3;
   logic [LW-1:0] clamp_init;
   logic [HASH_BITS-1:0] req_h;
   logic [63:0]   req_kmask;
   logic [3:0]    req_len;
   logic [HASH_BITS+4:0] h17;
   logic [AW-1:0] nidx;

   always_comb begin
      slots  = (AW+1)'(1) << size_ff;
      mask_w = slots - (AW+1)'(1);
      mask   = mask_w[AW-1:0];
      mask2  = {mask[AW-2:0], 1'b1};
      at_max = (32'(size_ff) >= 32'(MAX_LOG2_SLOTS));
      load4  = {count_ff, 2'b00};
      slots3 = (IW+3)'(slots) + (IW+3)'({slots, 1'b0});
      if (csr_wdata == '0) clamp_init = LW'(1);
      else if (32'(csr_wdata) > 32'(MAX_LOG2_SLOTS)) clamp_init = LW'(MAX_LOG2_SLOTS);
      else clamp_init = csr_wdata;
      req_h   = req_key_hash[HASH_BITS-1:0];
      req_len = (32'(req_key_length) > 32'(KEY_BYTES)) ? 4'(KEY_BYTES)
                                                       : req_key_length;
      req_kmask = (req_len >= 4'd8) ? '1 : ((64'd1 << {req_len, 3'b000}) - 64'd1);
      h17 = {hash_ff, 4'b0000} + (HASH_BITS+5)'(hash_ff);
      nidx = (idx_ff + step_ff) & (state_ff == dht_pkg::S_WPROBE ? mask2 : mask);
   end

   // active and rehash-target slot read data
   logic [SW-1:0] act_rd, new_rd;
   assign act_rd = sel_ff ? rb_data : ra_data;
   assign new_rd = sel_ff ? ra_data : rb_data;

   logic          slot_v;
   logic [IW-1:0] slot_id;
   logic          match;
   assign slot_v  = act_rd[SW-1];
   assign slot_id = act_rd[IW-1:0];
   assign match   = (er_data[EDW-1 -: HASH_BITS] == hash_ff) &&
                    (er_data[67:64] == len_ff) && (er_data[63:0] == key_ff);

   // sequencer
   always_comb begin
      state_in = state_ff;
      init_in = init_ff; size_in = size_ff; count_in = count_ff;
      srch_in = srch_ff; coll_in = coll_ff; exp_in = exp_ff; sel_in = sel_ff;
      ptr_in = ptr_ff; idx_in = idx_ff; step_in = step_ff; n_in = n_ff;
      op_in = op_ff; key_in = key_ff; len_in = len_ff; hash_in = hash_ff;
      id_in = id_ff; done_in = 1'b0; stat_in = stat_ff; rid_in = rid_ff;
      wa_en = 1'b0; wb_en = 1'b0; wa_addr = ptr_ff[AW-1:0];
      wb_addr = ptr_ff[AW-1:0]; wa_data = '0; wb_data = '0;
      ra_addr = idx_ff; rb_addr = idx_ff;
      ew_en = 1'b0; ew_addr = count_ff[IW-1:0];
      ew_data = {hash_ff, len_ff, key_ff}; er_addr = slot_id;
      case (state_ff)
         dht_pkg::S_CLEAR: begin
            wa_en = 1'b1; wb_en = 1'b1;
            ptr_in = ptr_ff + (AW+1)'(1);
            if (ptr_ff == (AW+1)'(SLOTS - 1)) state_in = dht_pkg::S_IDLE;
         end
         dht_pkg::S_IDLE: begin
            // take a word only once the previous result has gone out
            if (start && !done_ff) begin
               op_in   = req_operation;
               len_in  = req_len;
               key_in  = req_key_bytes & req_kmask;
               hash_in = req_h;
               idx_in  = AW'(req_h) & mask;
               n_in    = '0;
               srch_in = srch_ff + 32'd1;
               state_in = dht_pkg::S_RD;
            end
         end
         dht_pkg::S_RD: begin
            // slot read issued from idx
            step_in  = (AW'(h17) & mask) | AW'(1);
            state_in = dht_pkg::S_SLOT;
         end
         dht_pkg::S_SLOT: begin
            // slot data back; fetch entry
            if (!slot_v) begin
               stat_in = dht_pkg::ST_NOT_FOUND; rid_in = '0;
               if (op_ff == dht_pkg::OP_INSERT) begin
                  if (count_ff >= (IW+1)'(ENT_MAX) ||
                      (at_max && load4 >= slots3)) begin
                     stat_in = dht_pkg::ST_FULL;
                  end else begin
                     ew_en = 1'b1;
                     wa_en = !sel_ff; wb_en = sel_ff;
                     wa_addr = idx_ff; wb_addr = idx_ff;
                     wa_data = {1'b1, count_ff[IW-1:0]};
                     wb_data = {1'b1, count_ff[IW-1:0]};
                     count_in = count_ff + (IW+1)'(1);
                     stat_in = dht_pkg::ST_INSERTED;
                     rid_in = 12'(count_ff[IW-1:0]);
                  end
               end
               state_in = dht_pkg::S_DONE;
            end else begin
               state_in = dht_pkg::S_CMP;
            end
         end
         dht_pkg::S_CMP: begin
            if (match) begin
               stat_in = dht_pkg::ST_FOUND; rid_in = 12'(id_ff);
               state_in = dht_pkg::S_DONE;
            end else if (n_ff >= slots) begin
               stat_in = (op_ff == dht_pkg::OP_INSERT) ? dht_pkg::ST_FULL
                                                       : dht_pkg::ST_NOT_FOUND;
               rid_in = '0;
               state_in = dht_pkg::S_DONE;
            end else begin
               n_in = n_ff + (AW+1)'(1);
               coll_in = coll_ff + 32'd1;
               idx_in = nidx;
               state_in = dht_pkg::S_RD;
            end
         end
         dht_pkg::S_DONE: begin
            // grow when an insert reached 3/4 load
            if (stat_ff == dht_pkg::ST_INSERTED && !at_max && load4 >= slots3) begin
               ptr_in = '0;
               state_in = dht_pkg::S_WCLR;
            end else begin
               done_in = 1'b1;
               state_in = dht_pkg::S_IDLE;
            end
         end
         dht_pkg::S_WCLR: begin
            // clear the new table (twice the old size)
            wa_en = sel_ff; wb_en = !sel_ff;
            ptr_in = ptr_ff + (AW+1)'(1);
            if (ptr_ff[AW-1:0] == mask2) begin
               ptr_in = '0;
               state_in = dht_pkg::S_WRD;
            end
         end
         dht_pkg::S_WRD: begin
            ra_addr = ptr_ff[AW-1:0]; rb_addr = ptr_ff[AW-1:0];
            state_in = dht_pkg::S_WSLOT;
         end
         dht_pkg::S_WSLOT: begin
            // old slot back; read its hash
            id_in = slot_id;
            if (slot_v) begin
               state_in = dht_pkg::S_WPROBE;
               n_in = '0;
               idx_in = '1;
            end else begin
               ptr_in = ptr_ff + (AW+1)'(1);
               if (ptr_ff[AW-1:0] == mask) begin
                  sel_in = !sel_ff; size_in = size_ff + LW'(1);
                  exp_in = exp_ff + 4'd1; done_in = 1'b1;
                  state_in = dht_pkg::S_IDLE;
               end else state_in = dht_pkg::S_WRD;
            end
         end
         dht_pkg::S_WPROBE: begin
            // n: 0 wait entry, 1 compute index, 2 compute step, then probe reads
            er_addr = id_ff;
            ra_addr = idx_ff; rb_addr = idx_ff;
            if (n_ff == '0) begin
               n_in = (AW+1)'(1);
            end else if (n_ff == (AW+1)'(1)) begin
               hash_in = er_data[EDW-1 -: HASH_BITS];
               idx_in  = AW'(er_data[EDW-1 -: HASH_BITS]) & mask2;
               n_in    = (AW+1)'(2);
            end else if (n_ff == (AW+1)'(2)) begin
               step_in = (AW'(h17) & mask2) | AW'(1);
               n_in    = (AW+1)'(3);
            end else if (n_ff == (AW+1)'(3)) begin
               n_in = (AW+1)'(4);
            end else begin
               if (new_rd[SW-1]) begin
                  idx_in = nidx;
                  n_in = (AW+1)'(3);
               end else begin
                  wa_en = sel_ff; wb_en = !sel_ff;
                  wa_addr = idx_ff; wb_addr = idx_ff;
                  wa_data = {1'b1, id_ff}; wb_data = {1'b1, id_ff};
                  ptr_in = ptr_ff + (AW+1)'(1);
                  if (ptr_ff[AW-1:0] == mask) begin
                     sel_in = !sel_ff; size_in = size_ff + LW'(1);
                     exp_in = exp_ff + 4'd1; done_in = 1'b1;
                     state_in = dht_pkg::S_IDLE;
                  end else state_in = dht_pkg::S_WRD;
               end
            end
         end
         default: state_in = dht_pkg::S_IDLE;
      endcase
      if (state_ff == dht_pkg::S_SLOT) id_in = slot_id;
      // restart on a register write
      if (csr_we) begin
         init_in = clamp_init; size_in = clamp_init;
         count_in = '0; srch_in = '0; coll_in = '0; exp_in = '0; sel_in = 1'b0;
         ptr_in = '0; state_in = dht_pkg::S_CLEAR; done_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dht_pkg::S_CLEAR;
         init_ff <= LW'(4); size_ff <= LW'(4);
         count_ff <= '0; srch_ff <= '0; coll_ff <= '0; exp_ff <= '0;
         sel_ff <= 1'b0; ptr_ff <= '0; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff <= init_in; size_ff <= size_in; count_ff <= count_in;
         srch_ff <= srch_in; coll_ff <= coll_in; exp_ff <= exp_in;
         sel_ff <= sel_in; ptr_ff <= ptr_in; done_ff <= done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in; step_ff <= step_in; n_ff <= n_in; op_ff <= op_in;
      key_ff <= key_in; len_ff <= len_in; hash_ff <= hash_in; id_ff <= id_in;
      stat_ff <= stat_in; rid_ff <= rid_in;
   end

   assign busy = (state_ff != dht_pkg::S_IDLE) || done_ff;
   assign done = done_ff;
   assign rsp_status = stat_ff;
   assign rsp_entry_id = rid_ff;
   assign rsp_table_log2_slots = size_ff;
   assign rsp_search_count = srch_ff;
   assign rsp_collision_count = coll_ff;
   assign rsp_expansion_count = exp_ff;
endmodule
`default_nettype wire

/* sim/double_hash_table_find_or_insert_tb.sv */
// Self-checking testbench for the double hash table find-or-insert block.
`timescale 1ns / 1ps
module double_hash_table_find_or_insert_tb;
   localparam int MAX_L2      = dht_pkg::MAX_LOG2_SLOTS_DEF;
   localparam int SLOT_CAP    = 1 << MAX_L2;
   localparam int ENTRY_CAP   = (SLOT_CAP / 4) * 3;
   localparam int FILL_COUNT  = (SLOT_CAP / 8) * 3 + 4;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int CFG_SETTLE  = 40;

   typedef struct {
      bit          is_cfg;
      logic [3:0]  cfg;
      logic        op;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] hash;
      int          idle;
   } word_type;

   typedef struct {
      logic [1:0]  status;
      logic [11:0] id;
      logic [3:0]  log2;
      logic [31:0] searches;
      logic [31:0] collisions;
      logic [3:0]  expansions;
   } lookup_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = 1'b0;
   logic [63:0] req_key_bytes = '0;
   logic [3:0]  req_key_length = '0;
   logic [31:0] req_key_hash = '0;
   logic        done;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_entry_id;
   logic [3:0]  rsp_table_log2_slots;
   logic [31:0] rsp_search_count;
   logic [31:0] rsp_collision_count;
   logic [3:0]  rsp_expansion_count;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;

   double_hash_table_find_or_insert uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_key_bytes(req_key_bytes),
      .req_key_length(req_key_length), .req_key_hash(req_key_hash),
      .done(done), .rsp_status(rsp_status), .rsp_entry_id(rsp_entry_id),
      .rsp_table_log2_slots(rsp_table_log2_slots),
      .rsp_search_count(rsp_search_count),
      .rsp_collision_count(rsp_collision_count),
      .rsp_expansion_count(rsp_expansion_count),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the table
   logic [12:0] slot_mem [0:1][0:SLOT_CAP-1];
   bit          live_sel;
   logic [31:0] ent_hash [0:ENTRY_CAP-1];
   logic [63:0] ent_key  [0:ENTRY_CAP-1];
   logic [3:0]  ent_len  [0:ENTRY_CAP-1];
   int unsigned size_l2, elems;
   logic [31:0] searches, collisions;
   logic [3:0]  expansions, start_l2;

   word_type   pending_words[$];
   lookup_type expected_lookups[$];
   int      mismatches = 0;
   int      lookups_seen = 0;
   int      hits = 0, inserts = 0, misses = 0, refusals = 0;

   function automatic logic [63:0] len_mask(logic [3:0] len);
      if (len >= 8) return '1;
      return (64'd1 << (8 * len)) - 64'd1;
   endfunction

   // Empty both tables and start over at the configured size
   function automatic void restart_table();
      for (int t = 0; t < 2; t++)
         for (int i = 0; i < SLOT_CAP; i++) slot_mem[t][i] = '0;
      size_l2 = (start_l2 == 0) ? 1 : (start_l2 > MAX_L2) ? MAX_L2 : start_l2;
      elems = 0;
      searches = '0;
      collisions = '0;
      expansions = '0;
      live_sel = 1'b0;
   endfunction

   // Rehash every live slot into the other table at twice the size
   function automatic void grow_table();
      bit          fresh;
      int unsigned new_slots, mask, idx, step, n;
      logic [31:0] h, h17;
      logic [12:0] s;
      fresh = !live_sel;
      new_slots = 2 << size_l2;
      mask = new_slots - 1;
      for (int i = 0; i < SLOT_CAP; i++) slot_mem[fresh][i] = '0;
      for (int i = 0; i < (1 << size_l2); i++) begin
         s = slot_mem[live_sel][i];
         if (!s[12]) continue;
         h = ent_hash[s[11:0]];
         h17 = h * 32'd17;
         idx = h & mask;
         step = (h17 & mask) | 1;
         n = 0;
         while (n < new_slots && slot_mem[fresh][idx][12]) begin
            idx = (idx + step) & mask;
            n++;
         end
         if (!slot_mem[fresh][idx][12]) slot_mem[fresh][idx] = {1'b1, s[11:0]};
      end
      live_sel = fresh;
      size_l2++;
      expansions++;
   endfunction

   // Probe the live table for one request and update the shadow state
   function automatic lookup_type serve_request(word_type w);
      lookup_type  r;
      logic [3:0]  len;
      logic [63:0] key;
      logic [31:0] h17;
      logic [12:0] s;
      int unsigned slots, mask, idx, step, n;
      bit          found, empty, at_max;
      len = (w.len > dht_pkg::KEY_BYTES_DEF) ? 4'(dht_pkg::KEY_BYTES_DEF) : w.len;
      key = w.key & len_mask(len);
      slots = 1 << size_l2;
      mask = slots - 1;
      h17 = w.hash * 32'd17;
      idx = w.hash & mask;
      step = (h17 & mask) | 1;
      n = 0;
      found = 0;
      empty = 0;
      r.status = dht_pkg::ST_NOT_FOUND;
      r.id = '0;
      searches++;
      forever begin
         s = slot_mem[live_sel][idx];
         if (!s[12]) begin
            empty = 1;
            break;
         end
         if (ent_hash[s[11:0]] == w.hash && ent_len[s[11:0]] == len &&
             ent_key[s[11:0]] == key) begin
            found = 1;
            r.id = s[11:0];
            break;
         end
         if (n >= slots) break;
         n++;
         collisions++;
         idx = (idx + step) & mask;
      end
      if (found) begin
         r.status = dht_pkg::ST_FOUND;
      end else if (w.op == dht_pkg::OP_INSERT) begin
         at_max = size_l2 >= MAX_L2;
         if (!empty || elems >= ENTRY_CAP || (at_max && elems * 4 >= slots * 3)) begin
            r.status = dht_pkg::ST_FULL;
         end else begin
            ent_hash[elems] = w.hash;
            ent_key[elems] = key;
            ent_len[elems] = len;
            slot_mem[live_sel][idx] = {1'b1, 12'(elems)};
            r.status = dht_pkg::ST_INSERTED;
            r.id = 12'(elems);
            elems++;
            if (!at_max && elems * 4 >= slots * 3) grow_table();
         end
      end
      r.log2 = size_l2[3:0];
      r.searches = searches;
      r.collisions = collisions;
      r.expansions = expansions;
      return r;
   endfunction

   // Driver: present queued words, write the register only when drained
   int quiet_cycles = 0;
   always @(posedge clock) begin : driver
      word_type w;
      logic     nxt_start, nxt_we;
      nxt_start = start;
      nxt_we = 1'b0;
      if (!reset) begin
         quiet_cycles = (expected_lookups.size() == 0 && !start) ? quiet_cycles + 1 : 0;
         if (start && !busy) begin
            w.is_cfg = 0;
            w.op = req_operation;
            w.key = req_key_bytes;
            w.len = req_key_length;
            w.hash = req_key_hash;
            expected_lookups.push_back(serve_request(w));
            nxt_start = 1'b0;
         end
         if (!(start && busy) && !csr_we && pending_words.size() != 0) begin
            w = pending_words[0];
            if (w.is_cfg) begin
               if (!nxt_start && quiet_cycles > CFG_SETTLE && !busy) begin
                  void'(pending_words.pop_front());
                  nxt_we = 1'b1;
                  csr_wdata <= w.cfg;
                  start_l2 = w.cfg;
                  restart_table();
                  quiet_cycles = 0;
               end
            end else if ($urandom_range(99) >= w.idle) begin
               void'(pending_words.pop_front());
               nxt_start = 1'b1;
               req_operation <= w.op;
               req_key_bytes <= w.key;
               req_key_length <= w.len;
               req_key_hash <= w.hash;
            end
         end
      end
      start <= nxt_start;
      csr_we <= nxt_we;
   end

   // Monitor: check each result word against the oldest expectation
   always @(posedge clock) begin : monitor
      lookup_type e;
      if (!reset && done) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected result word, status %0d id %0d", $time,
                     rsp_status, rsp_entry_id);
            mismatches++;
         end else begin
            e = expected_lookups.pop_front();
            lookups_seen++;
            case (e.status)
               dht_pkg::ST_FOUND: hits++;
               dht_pkg::ST_INSERTED: inserts++;
               dht_pkg::ST_NOT_FOUND: misses++;
               default: refusals++;
            endcase
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               mismatches++;
            end
            if (rsp_entry_id !== e.id) begin
               $display("%0t: entry_id expected %0d actual %0d", $time, e.id, rsp_entry_id);
               mismatches++;
            end
            if (rsp_table_log2_slots !== e.log2) begin
               $display("%0t: table_log2_slots expected %0d actual %0d", $time, e.log2,
                        rsp_table_log2_slots);
               mismatches++;
            end
            if (rsp_search_count !== e.searches) begin
               $display("%0t: search_count expected %0d actual %0d", $time, e.searches,
                        rsp_search_count);
               mismatches++;
            end
            if (rsp_collision_count !== e.collisions) begin
               $display("%0t: collision_count expected %0d actual %0d", $time, e.collisions,
                        rsp_collision_count);
               mismatches++;
            end
            if (rsp_expansion_count !== e.expansions) begin
               $display("%0t: expansion_count expected %0d actual %0d", $time, e.expansions,
                        rsp_expansion_count);
               mismatches++;
            end
         end
      end
   end

   // Guard against a hung block
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Key pool used to revisit earlier keys
   logic [63:0] pool_key[$];
   logic [3:0]  pool_len[$];
   logic [31:0] pool_hash[$];

   task automatic add_lookup(logic op, logic [63:0] key, logic [3:0] len,
                             logic [31:0] hash, int idle);
      word_type w;
      w.is_cfg = 0;
      w.cfg = '0;
      w.op = op;
      w.key = key;
      w.len = len;
      w.hash = hash;
      w.idle = idle;
      pending_words.push_back(w);
   endtask

   task automatic add_cfg(logic [3:0] value);
      word_type w;
      w = '{default: '0};
      w.is_cfg = 1;
      w.cfg = value;
      pending_words.push_back(w);
      pool_key.delete();
      pool_len.delete();
      pool_hash.delete();
   endtask

   // Mix fresh keys, repeats with junk above the length, and forced hash clashes
   task automatic add_random(int count, int idle);
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] hash;
      int          pick, p;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         key = {$urandom, $urandom};
         len = 4'($urandom_range(15));
         hash = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom;
         if (pool_key.size() != 0 && pick < 45) begin
            p = $urandom_range(pool_key.size() - 1);
            key = pool_key[p] | (key & ~len_mask(pool_len[p]));
            len = pool_len[p];
            hash = pool_hash[p];
         end else if (pool_key.size() != 0 && pick < 55) begin
            hash = pool_hash[$urandom_range(pool_hash.size() - 1)];
         end else if (len < 8 && pick < 80) begin
            key = key & len_mask(len);
         end
         if (pick >= 55) begin
            pool_key.push_back(key & len_mask(len > 8 ? 4'd8 : len));
            pool_len.push_back(len);
            pool_hash.push_back(hash);
         end
         add_lookup($urandom_range(99) < 60 ? dht_pkg::OP_INSERT : dht_pkg::OP_SEARCH,
                    key, len, hash, idle);
      end
   endtask

   initial begin
      start_l2 = 4'd4;
      restart_table();

      // Directed words at the reset size
      add_lookup(dht_pkg::OP_SEARCH, 64'd0, 4'd0, 32'd0, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'd0, 4'd0, 32'd0, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'd0, 4'd0, 32'd0, 24);
      add_lookup(dht_pkg::OP_INSERT, '1, 4'd8, '1, 24);
      add_lookup(dht_pkg::OP_SEARCH, '1, 4'd15, '1, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'h1234_5678_9abc_def0, 4'd15, 32'h8000_0001, 24);
      add_lookup(dht_pkg::OP_SEARCH, 64'hffff_ff00_0000_00aa, 4'd1, 32'h10, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'h0000_0000_0000_00aa, 4'd1, 32'h10, 24);
      add_lookup(dht_pkg::OP_SEARCH, 64'hdead_beef_0000_00aa, 4'd1, 32'h10, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'h0000_0000_0000_00bb, 4'd1, 32'h10, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'h0000_0000_0000_00aa, 4'd2, 32'h10, 24);
      add_lookup(dht_pkg::OP_SEARCH, 64'h0000_0000_0000_00bb, 4'd1, 32'h10, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 4'd7, 32'h20, 24);
      add_lookup(dht_pkg::OP_INSERT, 64'h0000_0000_0000_0001, 4'd3, 32'h30, 24);
      add_lookup(dht_pkg::OP_SEARCH, 64'h0000_0000_0000_0002, 4'd3, 32'h30, 24);
      add_lookup(dht_pkg::OP_SEARCH, 64'h5555_5555_5555_5555, 4'd7, 32'h20, 24);

      // Zero counts as the smallest table
      add_cfg(4'd0);
      add_random(120, 24);
      add_cfg(4'd12);
      add_random(120, 46);
      add_cfg(4'd15);
      add_random(40, 46);

      // Grow from two slots through every doubling up to the largest size
      add_cfg(4'd1);
      for (int i = 0; i < FILL_COUNT; i++)
         add_lookup(dht_pkg::OP_INSERT, 64'(i) | (64'($urandom) << 32), 4'd8, $urandom, 0);
      add_lookup(dht_pkg::OP_SEARCH, 64'd5, 4'd3, 32'd0, 0);
      for (int i = 0; i < 6; i++)
         add_lookup(1'($urandom_range(1)), {$urandom, $urandom}, 4'd8, $urandom, 0);

      add_cfg(4'd5);
      add_random(20, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || start || expected_lookups.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      $display("checked %0d result words: %0d found, %0d inserted, %0d not found, %0d full",
               lookups_seen, hits, inserts, misses, refusals);
      $display("start sizes 0 (as 1), 1 grown to 12, 4, 5, 12, 15 (as 12); %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* filelist.f */
sv/dht_pkg.sv
sv/dht_slot_ram.sv
sv/dht_entry_ram.sv
sv/double_hash_table_find_or_insert.sv
sim/double_hash_table_find_or_insert_tb.sv
